// ===== src/sps_pkg.sv =====
// Shared types, constants and phase tables for the stepper phase sequencer.
package sps_pkg;

   localparam int GROUPS_PER_TURN_DEF = 512;

   localparam int AMOUNT_W = 20;
   localparam int REV_W    = 16;
   localparam int PHASES_W = 24;
   localparam int DELAY_W  = 15;
   localparam int COIL_W   = 4;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_BIT = 2;

   localparam logic [REV_W-1:0]    REV_RESET  = 16'd6000;
   localparam logic [PHASES_W-1:0] PHASES_MAX = 24'hFF_FFFF;
   localparam logic [DELAY_W-1:0]  DELAY_MAX  = 15'h7FFF;

   localparam logic [COIL_W-1:0] HALF_TABLE [8] = '{4'h1, 4'h3, 4'h2, 4'h6,
                                                    4'h4, 4'hC, 4'h8, 4'h9};
   localparam logic [COIL_W-1:0] WAVE_TABLE [4] = '{4'h1, 4'h2, 4'h4, 4'h8};

   typedef enum logic [1:0] {
      CMD_MOVE_DEG = 2'd0,
      CMD_MOVE_GRP = 2'd1,
      CMD_STOP     = 2'd2,
      CMD_TICK     = 2'd3
   } command_type;

   typedef enum logic {
      REG_REV_TIME  = 1'b0,
      REG_WAVE_MODE = 1'b1
   } reg_index_type;

   typedef struct packed {
      command_type         command;
      logic                direction;
      logic [AMOUNT_W-1:0] amount;
   } req_type;

   typedef struct packed {
      logic [COIL_W-1:0] coil_pattern;
      logic              busy_res;
      logic              phase_advanced;
      logic              rejected;
   } rsp_type;

endpackage

// ===== src/sps_stream_if.sv =====
// Valid/ready word channel carrying one payload struct.
interface sps_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/stepper_phase_sequencer_core.sv =====
// Four-coil unipolar stepper sequencer: half-step and wave drive with tick-timed phases.
//
//  channel  | dir | handshake          | word
//  ---------+-----+--------------------+-----------------------------------------------
//  req      | in  | valid/ready        | command, direction, amount
//  rsp      | out | valid/ready        | coil_pattern, busy_res, phase_advanced, rejected
//  csr      | in  | APB, pready tied 1 | 0x0 revolution_time_ms, 0x4 wave_mode
//
// One word per clock while rsp is not stalled: an accepted word is held in the input
// register, and its result is loaded into the output register when that word advances.
// The degree-to-group reciprocal multiply (from the input register) and the step delay
// multiply (from rev_time_ff) form the longest path, into the state/result registers.
// Reset is synchronous; it idles the motor, turns the coils off and loads 6000 ms.
// A stalled rsp holds the input register, and req.ready drops only when both are full.
module stepper_phase_sequencer_core
   import sps_pkg::*;
#(
   parameter int GROUPS_PER_TURN = GROUPS_PER_TURN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   sps_stream_if.sink            req,
   sps_stream_if.source          rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // groups = floor(amount*G/360) via reciprocal; exact for all 20-bit amounts
   localparam int DEG_SHIFT = AMOUNT_W + 9;
   localparam int DEG_MW    = $clog2(GROUPS_PER_TURN) + 21;
   localparam longint unsigned DEG_MULT_L =
      ((longint'(GROUPS_PER_TURN) << DEG_SHIFT) + 64'd359) / 64'd360;
   localparam logic [DEG_MW-1:0] DEG_MULT = DEG_MW'(DEG_MULT_L);
   localparam int DEG_PW = AMOUNT_W + DEG_MW;
   localparam int GRP_W  = DEG_PW - DEG_SHIFT;
   localparam int GW     = (GRP_W > AMOUNT_W) ? GRP_W : AMOUNT_W;
   localparam int TOT_W  = (GW + 3 > PHASES_W + 1) ? GW + 3 : PHASES_W + 1;

   // per_group = floor(rev*1000/G) via reciprocal; exact for all 16-bit times
   localparam int TICK_SHIFT = REV_W + $clog2(GROUPS_PER_TURN);
   localparam int TICK_MW    = $clog2(1000) + REV_W + 1;
   localparam longint unsigned TICK_MULT_L =
      ((64'd1000 << TICK_SHIFT) + longint'(GROUPS_PER_TURN) - 64'd1)
      / longint'(GROUPS_PER_TURN);
   localparam logic [TICK_MW-1:0] TICK_MULT = TICK_MW'(TICK_MULT_L);
   localparam int TICK_PW = REV_W + TICK_MW;
   localparam int PG_W    = TICK_PW - TICK_SHIFT;

   // config registers
   logic [REV_W-1:0] rev_time_ff;
   logic             wave_mode_ff;

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type item_ff;

   // motor state
   logic [2:0]          half_phase_ff, half_phase_in;
   logic [1:0]          wave_phase_ff, wave_phase_in;
   logic [PHASES_W-1:0] phases_left_ff, phases_left_in;
   logic [DELAY_W-1:0]  delay_left_ff, delay_left_in;
   logic [COIL_W-1:0]   coil_ff, coil_in;
   logic                move_dir_ff, move_dir_in;
   logic                moving_ff, moving_in;

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   logic advance;

   logic                csr_write;
   reg_index_type       csr_index;

   logic [DEG_PW-1:0]   deg_prod;
   logic [GW-1:0]       groups;
   logic [TOT_W-1:0]    total;
   logic [PHASES_W-1:0] total_sat;

   logic [TICK_PW-1:0]  tick_prod;
   logic [PG_W-1:0]     per_group;
   logic [PG_W-1:0]     ticks_raw;
   logic [DELAY_W-1:0]  phase_ticks;

   logic                apply_dir;
   logic [COIL_W-1:0]   apply_coil;
   logic [DELAY_W-1:0]  delay_dec;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_IDX_BIT]);

   always_comb begin
      case (csr_index)
         REG_REV_TIME:  csr_prdata = CSR_DATA_W'(rev_time_ff);
         REG_WAVE_MODE: csr_prdata = CSR_DATA_W'(wave_mode_ff);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rev_time_ff  <= REV_RESET;
         wave_mode_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_REV_TIME:  rev_time_ff  <= csr_pwdata[REV_W-1:0];
            REG_WAVE_MODE: wave_mode_ff <= csr_pwdata[0];
            default:       ;
         endcase
      end
   end

   // ---------------- handshake ----------------
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready   = !in_valid_ff || advance;
   assign in_valid_in = req.ready ? req.valid : in_valid_ff;

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   // ---------------- arithmetic ----------------
   assign deg_prod = DEG_PW'(item_ff.amount) * DEG_PW'(DEG_MULT);
   assign groups   = (item_ff.command == CMD_MOVE_DEG) ? GW'(deg_prod[DEG_PW-1:DEG_SHIFT])
                                                       : GW'(item_ff.amount);
   assign total    = wave_mode_ff ? (TOT_W'(groups) << 2) : (TOT_W'(groups) << 3);
   assign total_sat = (total > TOT_W'(PHASES_MAX)) ? PHASES_MAX : total[PHASES_W-1:0];

   assign tick_prod = TICK_PW'(rev_time_ff) * TICK_PW'(TICK_MULT);
   assign per_group = tick_prod[TICK_PW-1:TICK_SHIFT];
   assign ticks_raw = wave_mode_ff ? (per_group >> 2) : (per_group >> 3);

   always_comb begin
      if (ticks_raw == '0) begin
         phase_ticks = DELAY_W'(1);
      end else if (ticks_raw > PG_W'(DELAY_MAX)) begin
         phase_ticks = DELAY_MAX;
      end else begin
         phase_ticks = DELAY_W'(ticks_raw);
      end
   end

   // pattern for the next phase; counter clockwise reads the table backwards
   assign apply_dir = (item_ff.command == CMD_TICK) ? move_dir_ff : item_ff.direction;
   assign apply_coil = wave_mode_ff ? WAVE_TABLE[wave_phase_ff ^ {2{~apply_dir}}]
                                    : HALF_TABLE[half_phase_ff ^ {3{~apply_dir}}];
   assign delay_dec = delay_left_ff - DELAY_W'(delay_left_ff != '0);

   // ---------------- next state and result ----------------
   always_comb begin
      logic do_apply;
      logic advanced;
      logic rejected;

      do_apply       = 1'b0;
      advanced       = 1'b0;
      rejected       = 1'b0;
      half_phase_in  = half_phase_ff;
      wave_phase_in  = wave_phase_ff;
      phases_left_in = phases_left_ff;
      delay_left_in  = delay_left_ff;
      coil_in        = coil_ff;
      move_dir_in    = move_dir_ff;
      moving_in      = moving_ff;

      case (item_ff.command)
         CMD_MOVE_DEG, CMD_MOVE_GRP: begin
            if (moving_ff) begin
               rejected = 1'b1;
            end else if (groups != '0) begin
               do_apply       = 1'b1;
               move_dir_in    = item_ff.direction;
               moving_in      = 1'b1;
               phases_left_in = total_sat - PHASES_W'(1);
            end
         end
         CMD_STOP: begin
            coil_in        = '0;
            phases_left_in = '0;
            delay_left_in  = '0;
            moving_in      = 1'b0;
         end
         CMD_TICK: begin
            if (moving_ff) begin
               delay_left_in = delay_dec;
               if (delay_dec == '0) begin
                  if (phases_left_ff != '0) begin
                     do_apply       = 1'b1;
                     phases_left_in = phases_left_ff - PHASES_W'(1);
                  end else begin
                     moving_in = 1'b0;
                  end
               end
            end
         end
         default: ;
      endcase

      if (do_apply) begin
         advanced      = 1'b1;
         coil_in       = apply_coil;
         delay_left_in = phase_ticks;
         if (wave_mode_ff) begin
            wave_phase_in = wave_phase_ff + 2'd1;
         end else begin
            half_phase_in = half_phase_ff + 3'd1;
         end
      end

      rsp_data_in.coil_pattern   = coil_in;
      rsp_data_in.busy_res       = moving_in;
      rsp_data_in.phase_advanced = advanced;
      rsp_data_in.rejected       = rejected;
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         half_phase_ff  <= '0;
         wave_phase_ff  <= '0;
         phases_left_ff <= '0;
         delay_left_ff  <= '0;
         coil_ff        <= '0;
         move_dir_ff    <= 1'b0;
         moving_ff      <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            rsp_valid_ff   <= 1'b1;
            half_phase_ff  <= half_phase_in;
            wave_phase_ff  <= wave_phase_in;
            phases_left_ff <= phases_left_in;
            delay_left_ff  <= delay_left_in;
            coil_ff        <= coil_in;
            move_dir_ff    <= move_dir_in;
            moving_ff      <= moving_in;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         item_ff <= req.payload;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ---------------- assertions ----------------
   a_moving_coils_on : assert property (@(posedge clock) disable iff (reset)
      moving_ff |-> coil_ff != '0)
      else $error("motor moving with all coils off");

   a_phases_need_move : assert property (@(posedge clock) disable iff (reset)
      phases_left_ff != '0 |-> moving_ff)
      else $error("phases left while idle");

   a_delay_need_move : assert property (@(posedge clock) disable iff (reset)
      delay_left_ff != '0 |-> moving_ff)
      else $error("delay pending while idle");

   a_advance_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.phase_advanced |-> rsp_data_ff.busy_res
         && !rsp_data_ff.rejected)
      else $error("advanced word not busy or also rejected");

   a_result_follows_input : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed word lost before output register");

endmodule
